>>> rtl/dfd_pkg.sv
// Package for the DLE frame deframer: framing byte codes, result kinds,
// payload limit and the widths derived from it. No dependencies.
package dfd_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] kind_type;

   // Largest number of payload bytes accepted in one frame.
   localparam int MAX_PAYLOAD = 512;

   // The running count must be able to hold MAX_PAYLOAD itself.
   localparam int COUNT_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int PCOUNT_W = 10;

   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [PCOUNT_W-1:0] pcount_type;

   localparam count_type COUNT_MAX = count_type'(MAX_PAYLOAD);

   // Framing bytes.
   localparam byte_type DLE = 8'h10;
   localparam byte_type STX = 8'h02;
   localparam byte_type ETX = 8'h03;
   localparam byte_type NUL = 8'h00;

   // Result kinds.
   localparam kind_type K_FUNC    = 3'd0;
   localparam kind_type K_PAYLOAD = 3'd1;
   localparam kind_type K_GOOD    = 3'd2;
   localparam kind_type K_CKERR   = 3'd3;
   localparam kind_type K_STUFF   = 3'd4;
   localparam kind_type K_OVER    = 3'd5;

endpackage

>>> rtl/dfd_channels.sv
// Valid/ready channel interfaces for the DLE frame deframer: the received
// byte stream and the result stream. Depends on dfd_pkg.
interface dfd_req_if
   import dfd_pkg::*;
   ();
   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfd_rsp_if
   import dfd_pkg::*;
   ();
   logic       valid;
   logic       ready;
   kind_type   out_kind;
   byte_type   out_byte;
   pcount_type payload_count;

   modport source (output valid, output out_kind, output out_byte, output payload_count,
                   input ready);
   modport sink   (input valid, input out_kind, input out_byte, input payload_count,
                   output ready);
endinterface

>>> rtl/dle_frame_deframer.sv
// DLE byte-stuffed frame deframer, top level.
// Depends on dfd_pkg and the channel interfaces in dfd_channels.sv.
//
// Usage: received bytes enter one per transaction on req_chan. The block
// hunts for the start sequence 0x10 0x02 0x00, reads the (possibly stuffed)
// function byte, then unstuffs payload bytes until 0x10 0x03, and checks the
// byte after that pair as the inverted 8-bit sum of function and payload.
// Each input byte produces zero or one result transaction on rsp_chan: the
// function code, a payload byte with its running count, or a final verdict
// (good end, checksum error, stuffing error or overflow).
// Latency: a result appears on rsp_chan in the cycle after its byte is
// accepted. Throughput: one byte per cycle when not stalled; the frame state
// update is a single short step, and the result register is the only stage.
// Stalls: a result waiting in the output register does not block input as
// long as the receiver takes it in the same cycle; req_chan.ready is low only
// while a result is held and rsp_chan.ready is low.
// Reset (synchronous, active high) returns the block to hunting for the
// start DLE with the sum and count cleared, and drops any pending result.
module dle_frame_deframer
   import dfd_pkg::*;
   (
   input  logic       clock,
   input  logic       reset,
   dfd_req_if.sink    req_chan,
   dfd_rsp_if.source  rsp_chan
   );

   // Frame phase codes.
   localparam logic [2:0] PH_HUNT_DLE = 3'd0;
   localparam logic [2:0] PH_HUNT_STX = 3'd1;
   localparam logic [2:0] PH_HUNT_NUL = 3'd2;
   localparam logic [2:0] PH_FUNC     = 3'd3;
   localparam logic [2:0] PH_FUNC_DLE = 3'd4;
   localparam logic [2:0] PH_PAYLOAD  = 3'd5;
   localparam logic [2:0] PH_PAY_DLE  = 3'd6;
   localparam logic [2:0] PH_CHECK    = 3'd7;

   logic [2:0] phase_ff, phase_in;
   byte_type   sum_ff, sum_in;
   count_type  count_ff, count_in;

   logic       res_valid_ff, res_valid_in;
   kind_type   kind_ff, kind_in;
   byte_type   byte_ff, byte_in;
   pcount_type pcount_ff, pcount_in;

   logic     accept;
   byte_type b;

   // The output register can take a new result when it is empty or being
   // drained in this cycle.
   assign req_chan.ready = !res_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.rx_byte;

   // Next-state and result logic for one received byte.
   always_comb begin
      phase_in     = phase_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      res_valid_in = 1'b0;
      kind_in      = K_FUNC;
      byte_in      = '0;
      pcount_in    = '0;
      case (phase_ff)
         PH_HUNT_STX: begin
            if (b == STX) begin
               phase_in = PH_HUNT_NUL;
            end else if (b == DLE) begin
               phase_in = PH_HUNT_STX;
            end else begin
               phase_in = PH_HUNT_DLE;
            end
         end
         PH_HUNT_NUL: begin
            if (b == NUL) begin
               phase_in = PH_FUNC;
            end else if (b == DLE) begin
               phase_in = PH_HUNT_STX;
            end else begin
               phase_in = PH_HUNT_DLE;
            end
         end
         PH_FUNC, PH_FUNC_DLE: begin
            count_in = '0;
            if (phase_ff == PH_FUNC && b == DLE) begin
               // First half of a stuffed function byte.
               sum_in   = '0;
               phase_in = PH_FUNC_DLE;
            end else if (phase_ff == PH_FUNC_DLE && b != DLE) begin
               sum_in       = '0;
               res_valid_in = 1'b1;
               kind_in      = K_STUFF;
               phase_in     = PH_HUNT_DLE;
            end else begin
               sum_in       = b;
               res_valid_in = 1'b1;
               kind_in      = K_FUNC;
               byte_in      = b;
               phase_in     = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD, PH_PAY_DLE: begin
            if (phase_ff == PH_PAYLOAD && b == DLE) begin
               phase_in = PH_PAY_DLE;
            end else if (phase_ff == PH_PAY_DLE && b == ETX) begin
               phase_in = PH_CHECK;
            end else if (phase_ff == PH_PAY_DLE && b != DLE) begin
               // A lone DLE inside the payload aborts the frame.
               res_valid_in = 1'b1;
               kind_in      = K_STUFF;
               pcount_in    = pcount_type'(count_ff);
               phase_in     = PH_HUNT_DLE;
            end else if (count_ff >= COUNT_MAX) begin
               res_valid_in = 1'b1;
               kind_in      = K_OVER;
               pcount_in    = pcount_type'(COUNT_MAX);
               phase_in     = PH_HUNT_DLE;
            end else begin
               count_in     = count_ff + count_type'(1);
               sum_in       = sum_ff + b;
               res_valid_in = 1'b1;
               kind_in      = K_PAYLOAD;
               byte_in      = b;
               pcount_in    = pcount_type'(count_ff + count_type'(1));
               phase_in     = PH_PAYLOAD;
            end
         end
         PH_CHECK: begin
            res_valid_in = 1'b1;
            kind_in      = (sum_ff == ~b) ? K_GOOD : K_CKERR;
            pcount_in    = pcount_type'(count_ff);
            phase_in     = PH_HUNT_DLE;
         end
         default: begin
            phase_in = (b == DLE) ? PH_HUNT_STX : PH_HUNT_DLE;
         end
      endcase
   end

   // Frame state advances only on an accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT_DLE;
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   // Result register: loaded on every accepted byte, emptied when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (accept) begin
         res_valid_ff <= res_valid_in;
      end else if (rsp_chan.ready) begin
         res_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         pcount_ff <= pcount_in;
      end
   end

   assign rsp_chan.valid         = res_valid_ff;
   assign rsp_chan.out_kind      = kind_ff;
   assign rsp_chan.out_byte      = byte_ff;
   assign rsp_chan.payload_count = pcount_ff;

`ifndef SYNTHESIS
   // The running count never passes the payload limit.
   assert property (@(posedge clock) disable iff (reset) count_ff <= COUNT_MAX)
      else $error("payload count passed the limit");

   // A pending verdict means the frame has ended and hunting has resumed.
   assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && kind_ff != K_FUNC && kind_ff != K_PAYLOAD
         |-> phase_ff == PH_HUNT_DLE && byte_ff == '0)
      else $error("verdict pending while a frame is still open");

   // A pending payload byte carries the count held in the frame state.
   assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && kind_ff == K_PAYLOAD
         |-> pcount_ff == pcount_type'(count_ff) && phase_ff == PH_PAYLOAD)
      else $error("payload result does not match frame state");

   // A pending function code leaves the frame at the payload with a zero count.
   assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && kind_ff == K_FUNC
         |-> count_ff == '0 && sum_ff == byte_ff && phase_ff == PH_PAYLOAD)
      else $error("function code result does not match frame state");
`endif

endmodule
